// ===== hdl/stream_duplicate_detector_core_macros.svh =====
// Assertion macros shared by the stream duplicate detector checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef STREAM_DUPLICATE_DETECTOR_CORE_MACROS_SVH
`define STREAM_DUPLICATE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdd assertion failed");

// Next-cycle implication, disabled during reset.
`define SDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdd assertion failed");

`endif

// ===== hdl/sdd_pkg.sv =====
// Shared constants and types of the stream duplicate detector.
// No dependencies.
`timescale 1ns / 1ps

package sdd_pkg;

    localparam int VALUE_W             = 32;
    localparam int TABLE_DEPTH_DEFAULT = 64;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/sdd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/stream_duplicate_detector_core.sv =====
// Top level of the stream duplicate detector: seen-value table scan and result register.
// Depends on sdd_pkg and sdd_ram.
`timescale 1ns / 1ps

// Usage
// - Input channel in_valid/in_ready carries one request: value and last_of_list.
// - Output channel out_valid/out_ready carries one result per request: element,
//   is_repeat, table_overflow and end_marker (copy of last_of_list).
// - The seen table lives in one RAM, read one entry per cycle. A request is
//   taken, then the stored entries below the fill count are scanned in order;
//   a match ends the scan early.
// - A new request is taken only after the result of the previous one has
//   entered the output register. The scan grows with count, the number of
//   distinct values stored so far in the current list (up to TABLE_DEPTH).
// - New values are written at the fill count; when the table is full a new
//   value is flagged table_overflow and not stored. The fill count returns to
//   zero after the last request of a list. Stored words are never cleared.
// - Reset empties the table at once (fill count to zero) and drops any result.
// - The result sits in an output register. A stalled receiver holds it there;
//   the next request is still taken and scanned, and waits for the register
//   only when its own result is ready.

module stream_duplicate_detector_core #(
    parameter int TABLE_DEPTH = sdd_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [sdd_pkg::VALUE_W-1:0] value,
    input  logic                              last_of_list,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [sdd_pkg::VALUE_W-1:0] element,
    output logic                              is_repeat,
    output logic                              table_overflow,
    output logic                              end_marker
);

    import sdd_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               hit_reg, hit_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg, last_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] element_reg, element_next;
    logic               repeat_reg, repeat_next;
    logic               ovf_reg, ovf_next;
    logic               end_reg, end_next;

    logic               mem_we;
    logic [VALUE_W-1:0] mem_rdata;

    logic               match;
    logic               scan_end;
    logic               full;
    logic               out_free;

    // Seen table: written at the fill count, read at the scan index.
    sdd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_seen_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (value_reg),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    assign match    = cmp_valid_reg && (mem_rdata == value_reg);
    assign scan_end = match || (idx_reg >= count_reg);
    assign full     = (count_reg == FULL_CNT);
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        hit_next       = hit_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        element_next   = element_reg;
        repeat_next    = repeat_reg;
        ovf_next       = ovf_reg;
        end_next       = end_reg;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = value;
                    last_next  = last_of_list;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // One read issued per cycle; data compared the cycle after.
                if (match)
                begin
                    hit_next = 1'b1;
                end
                else if (idx_reg < count_reg)
                begin
                    idx_next       = idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    element_next   = value_reg;
                    repeat_next    = hit_reg;
                    ovf_next       = !hit_reg && full;
                    end_next       = last_reg;
                    mem_we         = !hit_reg && !full;
                    if (last_reg)
                    begin
                        count_next = '0;
                    end
                    else if (!hit_reg && !full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
        element_reg <= element_next;
        repeat_reg  <= repeat_next;
        ovf_reg     <= ovf_next;
        end_reg     <= end_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign element        = signed'(element_reg);
    assign is_repeat      = repeat_reg;
    assign table_overflow = ovf_reg;
    assign end_marker     = end_reg;

endmodule

// ===== hdl/sdd_checker.sv =====
// Port-level checker of the stream duplicate detector, bound to the top level.
// Depends on sdd_pkg and stream_duplicate_detector_core_macros.svh.
`timescale 1ns / 1ps
`include "stream_duplicate_detector_core_macros.svh"

module sdd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic signed [sdd_pkg::VALUE_W-1:0] value,
    input logic                               last_of_list,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [sdd_pkg::VALUE_W-1:0] element,
    input logic                               is_repeat,
    input logic                               table_overflow,
    input logic                               end_marker
);

    import sdd_pkg::*;

    logic in_acc;
    logic out_stall;

    assign in_acc    = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // A stalled result holds.
    `SDD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(element) && $stable(is_repeat) && $stable(table_overflow) && $stable(end_marker))

    // A repeat never overflows.
    `SDD_ASSERT_NOW(a_flags_excl, clk, rst_n, out_valid, !(is_repeat && table_overflow))

    // One request in flight: no request taken in the cycle after one.
    `SDD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_acc, !in_ready)

    // A scan lies between acceptance and the result, so no result appears straight after acceptance.
    `SDD_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_acc, !$rose(out_valid))

endmodule

bind stream_duplicate_detector_core sdd_checker u_sdd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .value          (value),
    .last_of_list   (last_of_list),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .element        (element),
    .is_repeat      (is_repeat),
    .table_overflow (table_overflow),
    .end_marker     (end_marker)
);

// ===== dv/tb_stream_duplicate_detector_core.sv =====
// Self-checking testbench for stream_duplicate_detector_core: directed and random lists.
// Depends on sdd_pkg and the RTL of the block; the result predictor is held locally.
`timescale 1ns / 1ps

// One predicted result of the detector.
typedef struct {
    logic [sdd_pkg::VALUE_W-1:0] element;
    logic                        is_repeat;
    logic                        table_overflow;
    logic                        end_marker;
} dedup_result_t;

// Tracks the seen-value table of the current list and queues the result due for
// each accepted request.
class dedup_scoreboard;
    localparam int DEPTH = sdd_pkg::TABLE_DEPTH_DEFAULT;
    localparam int IDX_W = $clog2(DEPTH);

    logic [sdd_pkg::VALUE_W-1:0] seen_words [DEPTH];
    int unsigned                 seen_fill;
    dedup_result_t               awaited_results [$];
    int unsigned                 mismatches;

    function new();
        seen_fill  = 0;
        mismatches = 0;
    endfunction

    function void note_request(logic [sdd_pkg::VALUE_W-1:0] v, logic lst);
        dedup_result_t r;
        r.element        = v;
        r.is_repeat      = 1'b0;
        r.table_overflow = 1'b0;
        r.end_marker     = lst;
        for (int i = 0; i < seen_fill; i++)
            if (seen_words[IDX_W'(i)] == v)
                r.is_repeat = 1'b1;
        if (!r.is_repeat)
        begin
            if (seen_fill < DEPTH)
            begin
                seen_words[IDX_W'(seen_fill)] = v;
                seen_fill++;
            end
            else
                r.table_overflow = 1'b1;
        end
        if (lst)
            seen_fill = 0;
        awaited_results = {awaited_results, r};
    endfunction

    function void check_result(logic [sdd_pkg::VALUE_W-1:0] el, logic rep, logic ovf,
                               logic endm);
        dedup_result_t r;
        if (awaited_results.size() == 0)
        begin
            $error("result %h arrived with no request outstanding", el);
            mismatches++;
            return;
        end
        r = awaited_results.pop_front();
        if (el !== r.element)
        begin
            $error("element: expected %h, got %h", r.element, el);
            mismatches++;
        end
        if (rep !== r.is_repeat)
        begin
            $error("is_repeat: expected %b, got %b", r.is_repeat, rep);
            mismatches++;
        end
        if (ovf !== r.table_overflow)
        begin
            $error("table_overflow: expected %b, got %b", r.table_overflow, ovf);
            mismatches++;
        end
        if (endm !== r.end_marker)
        begin
            $error("end_marker: expected %b, got %b", r.end_marker, endm);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return awaited_results.size();
    endfunction
endclass

module tb_stream_duplicate_detector_core;
    import sdd_pkg::*;

    localparam int      TABLE_DEPTH  = TABLE_DEPTH_DEFAULT;
    localparam int      RANDOM_ITEMS = 1150;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      DRAIN_LIMIT  = 20000;
    localparam longint  LIMIT_NS     = 16_000_000;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic signed [VALUE_W-1:0]  value        = '0;
    logic                       last_of_list = 1'b0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic signed [VALUE_W-1:0]  element;
    logic                       is_repeat;
    logic                       table_overflow;
    logic                       end_marker;

    // Shared between sender and receiver: no idling inside the quiet stretch,
    // and a count of long receiver hold-offs asked for by the stimulus.
    bit                         quiet_stretch = 1'b0;
    int                         hold_requests = 0;
    int                         sent_count    = 0;

    dedup_scoreboard            sb = new();

    stream_duplicate_detector_core #(
        .TABLE_DEPTH    (TABLE_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .last_of_list   (last_of_list),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .element        (element),
        .is_repeat      (is_repeat),
        .table_overflow (table_overflow),
        .end_marker     (end_marker)
    );

    always #10 clk = ~clk;

    function automatic bit idle_now();
        return !quiet_stretch && ($urandom_range(99) < 12);
    endfunction

    // Offer one request at the falling edge and hold it until accepted.
    task automatic send_request(input logic [VALUE_W-1:0] v, input logic lst);
        @(negedge clk);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        value        <= v;
        last_of_list <= lst;
        sent_count++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Short list drawn mostly from a small pool, so repeats are common.
    task automatic short_list();
        logic [VALUE_W-1:0] pool [8];
        logic [VALUE_W-1:0] v;
        logic [2:0]         pick;
        int                 pool_size;
        int                 len;
        pool_size = $urandom_range(8, 1);
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(9))
                0:       pool[3'(i)] = 32'h8000_0000;
                1:       pool[3'(i)] = 32'h7fff_ffff;
                2:       pool[3'(i)] = 32'h0000_0000;
                3:       pool[3'(i)] = 32'hffff_ffff;
                default: pool[3'(i)] = $urandom;
            endcase
        end
        len = $urandom_range(24, 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) < 7)
            begin
                pick = 3'($urandom_range(pool_size - 1));
                v    = pool[pick];
            end
            else
                v = $urandom;
            send_request(v, i == len - 1);
        end
    endtask

    // Fill the table with distinct values, then a tail of repeats, new values
    // that spill over and second copies of a spilled value.
    task automatic full_list();
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] stride;
        logic [VALUE_W-1:0] spilled;
        logic [VALUE_W-1:0] v;
        int                 tail;
        base    = $urandom;
        stride  = $urandom | 32'd1;
        spilled = $urandom;
        tail    = $urandom_range(16, 0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(base + stride * 32'(i), tail == 0 && i == TABLE_DEPTH - 1);
        for (int i = 0; i < tail; i++)
        begin
            case ($urandom_range(2))
                0: v = base + stride * 32'($urandom_range(TABLE_DEPTH - 1));
                1:
                begin
                    spilled = $urandom;
                    v       = spilled;
                end
                default: v = spilled;
            endcase
            send_request(v, i == tail - 1);
        end
    endtask

    // Tiny lists of fully random words.
    task automatic noise_list();
        int len;
        len = $urandom_range(3, 1);
        for (int i = 0; i < len; i++)
            send_request($urandom, i == len - 1);
    endtask

    // Receiver: random idling, plus long hold-offs counted here.
    initial
    begin : receiver
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever
        begin
            @(negedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !idle_now();
        end
    end

    // Sample both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(value, last_of_list);
            if (out_valid && out_ready)
                sb.check_result(element, is_repeat, table_overflow, end_marker);
        end
    end

    initial
    begin : stimulus
        int kind;
        int drain;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme words, repeats, list end on a repeat.
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h7fff_ffff, 1'b0);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hffff_ffff, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'hffff_ffff, 1'b0);
        send_request(32'h7fff_ffff, 1'b1);
        // Single-request list: table must be empty again, so this is new.
        send_request(32'h8000_0000, 1'b1);
        send_request(32'h5555_5555, 1'b0);
        send_request(32'haaaa_aaaa, 1'b0);
        send_request(32'haaaa_aaaa, 1'b0);
        send_request(32'h5555_5555, 1'b1);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0001, 1'b1);

        // Random lists; table-full lists are weighted in so overflow is frequent.
        while (sent_count < 15 + RANDOM_ITEMS)
        begin
            if (hold_requests == 0 && sent_count > 150)
                hold_requests++;
            else if (hold_requests == 1 && sent_count > 800)
                hold_requests++;
            quiet_stretch = (sent_count >= 400 && sent_count < 600);
            kind = $urandom_range(99);
            if (kind < 70)
                short_list();
            else if (kind < 85)
                full_list();
            else
                noise_list();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        drain = 0;
        while (sb.outstanding() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (sb.outstanding() != 0)
        begin
            $error("%0d results never arrived", sb.outstanding());
            sb.mismatches++;
        end
        // Let any stray result show up before the verdict.
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("stream_duplicate_detector_core regression: pass");
        else
            $display("stream_duplicate_detector_core regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("stream_duplicate_detector_core regression: fail");
        $finish;
    end
endmodule
